>>> rtl/core/bdss_pkg.sv
// Shared constants for the block distortion (SAD/SSE) unit.
// No dependencies; used by bdss_term and block_distortion_sad_sse_unit.
package bdss_pkg;

    // Widths fixed by the port and register map
    localparam int SAMPLE_PORT_BITS = 16;
    localparam int DIST_BITS        = 48;
    localparam int DIM_BITS         = 7;
    localparam int LIMIT_BITS       = 31;
    localparam int CODE_BITS        = 32;

    // APB map: 32-bit registers on word addresses
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;
    localparam int REG_IDX_BITS  = 3;

    // Register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_METRIC_SELECT = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_EARLY_EXIT    = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_EXIT_LIMIT    = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_CUR_WIDTH     = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_CUR_HEIGHT    = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_REF_WIDTH     = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_REF_HEIGHT    = 3'd6;

    // Reset dimension and size-mismatch error code
    localparam logic [DIM_BITS-1:0]  DIM_RESET     = 7'd16;
    localparam logic [CODE_BITS-1:0] MISMATCH_CODE = 32'd10000000;

endpackage

>>> rtl/core/bdss_term.sv
// Sample input register and per-pair error term stage (|cur-ref| or its square).
// Depends on bdss_pkg for the sample port width.
module bdss_term #(
    parameter int SAMPLE_BITS = 16,
    localparam int TERM_BITS  = 2 * SAMPLE_BITS + 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [bdss_pkg::SAMPLE_PORT_BITS-1:0] i_cur_sample,
    input  logic [bdss_pkg::SAMPLE_PORT_BITS-1:0] i_ref_sample,
    input  logic                                  i_last_pair,
    input  logic                                  i_metric_sse,
    output logic                                  o_t_valid,
    input  logic                                  i_t_ready,
    output logic                                  o_t_last,
    output logic [TERM_BITS-1:0]                  o_term
);

    logic                   r_in_vld;
    logic [SAMPLE_BITS-1:0] r_cur;
    logic [SAMPLE_BITS-1:0] r_ref;
    logic                   r_in_last;
    logic                   r_t_vld;
    logic                   r_t_last;
    logic [TERM_BITS-1:0]   r_term;

    logic signed [SAMPLE_BITS:0]     diff;
    logic        [SAMPLE_BITS:0]     mag;
    logic        [2*SAMPLE_BITS+1:0] sq;
    logic        [TERM_BITS-1:0]     n_term;
    logic                            in_move;
    logic                            accept;

    // handshake: input stage moves on when the term stage is empty or draining
    assign in_move = r_in_vld && (!r_t_vld || i_t_ready);
    assign o_ready = !r_in_vld || !r_t_vld || i_t_ready;
    assign accept  = i_valid && o_ready;

    // difference, magnitude, optional square
    always_comb begin
        diff   = $signed({r_cur[SAMPLE_BITS-1], r_cur}) - $signed({r_ref[SAMPLE_BITS-1], r_ref});
        mag    = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : (SAMPLE_BITS+1)'(diff);
        sq     = mag * mag;
        n_term = i_metric_sse ? TERM_BITS'(sq) : TERM_BITS'(mag);
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (in_move) begin
            r_in_vld <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur     <= i_cur_sample[SAMPLE_BITS-1:0];
            r_ref     <= i_ref_sample[SAMPLE_BITS-1:0];
            r_in_last <= i_last_pair;
        end
    end

    // term register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else if (in_move) begin
            r_t_vld <= 1'b1;
        end else if (i_t_ready) begin
            r_t_vld <= 1'b0;
        end
    end

    // term register payload
    always_ff @(posedge i_clk) begin
        if (in_move) begin
            r_term   <= n_term;
            r_t_last <= r_in_last;
        end
    end

    assign o_t_valid = r_t_vld;
    assign o_t_last  = r_t_last;
    assign o_term    = r_term;

endmodule

>>> rtl/core/block_distortion_sad_sse_unit.sv
// Block distortion unit: SAD/SSE accumulation with early exit, APB registers.
// Depends on bdss_pkg and bdss_term.
//
//   channel   handshake               payload
//   -------   ---------------------   ---------------------------------------------
//   pairs in  i_valid / o_ready       i_cur_sample, i_ref_sample, i_last_pair
//   result    o_valid / i_ready       o_distortion, o_exited_early, o_size_mismatch
//   config    psel/penable/pwrite     paddr, pwdata, prdata, pready (always high)
//
// One pair per cycle while no result is stalled. A pair goes through the input
// register, then the term register, then the result register that presents its result.
// The per-cycle loop is the saturating add and limit compare on r_sum.
// Synchronous active-low reset clears the sum, the finished flag, the valid flags
// and resets the config registers. A stalled result only holds pairs that emit one.
module block_distortion_sad_sse_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS    = 48
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample pairs
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [bdss_pkg::SAMPLE_PORT_BITS-1:0] i_cur_sample,
    input  logic [bdss_pkg::SAMPLE_PORT_BITS-1:0] i_ref_sample,
    input  logic                                 i_last_pair,
    // results
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [bdss_pkg::DIST_BITS-1:0]       o_distortion,
    output logic                                 o_exited_early,
    output logic                                 o_size_mismatch,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bdss_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [bdss_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [bdss_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);

    localparam int TERM_BITS = 2 * SAMPLE_BITS + 1;
    localparam int ADD_BITS  = ((SUM_BITS > TERM_BITS) ? SUM_BITS : TERM_BITS) + 1;

    // configuration registers
    logic                              r_metric;
    logic                              r_early_en;
    logic [bdss_pkg::LIMIT_BITS-1:0]   r_limit;
    logic [bdss_pkg::DIM_BITS-1:0]     r_cur_w;
    logic [bdss_pkg::DIM_BITS-1:0]     r_cur_h;
    logic [bdss_pkg::DIM_BITS-1:0]     r_ref_w;
    logic [bdss_pkg::DIM_BITS-1:0]     r_ref_h;

    // accumulation state
    logic [SUM_BITS-1:0]               r_sum;
    logic                              r_fin;
    logic [SUM_BITS-1:0]               n_sum;
    logic                              n_fin;

    // result register
    logic                              r_o_vld;
    logic [bdss_pkg::DIST_BITS-1:0]    r_dist;
    logic                              r_early;
    logic                              r_mism;
    logic [bdss_pkg::DIST_BITS-1:0]    n_dist;
    logic                              n_early;
    logic                              n_mism;

    // term stage interface
    logic                              t_valid;
    logic                              t_ready;
    logic                              t_last;
    logic [TERM_BITS-1:0]              t_term;

    logic [bdss_pkg::REG_IDX_BITS-1:0] reg_idx;
    logic                              cfg_wr;
    logic                              mismatch;
    logic [ADD_BITS-1:0]               sum_wide;
    logic [SUM_BITS-1:0]               sum_sat;
    logic [bdss_pkg::CODE_BITS-1:0]    code;
    logic                              emit;
    logic                              out_free;
    logic                              t_move;

    bdss_term #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_term (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cur_sample (i_cur_sample),
        .i_ref_sample (i_ref_sample),
        .i_last_pair  (i_last_pair),
        .i_metric_sse (r_metric),
        .o_t_valid    (t_valid),
        .i_t_ready    (t_ready),
        .o_t_last     (t_last),
        .o_term       (t_term)
    );

    // APB decode
    assign reg_idx = paddr[bdss_pkg::APB_ADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric   <= 1'b0;
            r_early_en <= 1'b0;
            r_limit    <= '0;
            r_cur_w    <= bdss_pkg::DIM_RESET;
            r_cur_h    <= bdss_pkg::DIM_RESET;
            r_ref_w    <= bdss_pkg::DIM_RESET;
            r_ref_h    <= bdss_pkg::DIM_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                bdss_pkg::REG_METRIC_SELECT: r_metric   <= pwdata[0];
                bdss_pkg::REG_EARLY_EXIT:    r_early_en <= pwdata[0];
                bdss_pkg::REG_EXIT_LIMIT:    r_limit    <= pwdata[bdss_pkg::LIMIT_BITS-1:0];
                bdss_pkg::REG_CUR_WIDTH:     r_cur_w    <= pwdata[bdss_pkg::DIM_BITS-1:0];
                bdss_pkg::REG_CUR_HEIGHT:    r_cur_h    <= pwdata[bdss_pkg::DIM_BITS-1:0];
                bdss_pkg::REG_REF_WIDTH:     r_ref_w    <= pwdata[bdss_pkg::DIM_BITS-1:0];
                bdss_pkg::REG_REF_HEIGHT:    r_ref_h    <= pwdata[bdss_pkg::DIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (reg_idx)
            bdss_pkg::REG_METRIC_SELECT: prdata = bdss_pkg::APB_DATA_BITS'(r_metric);
            bdss_pkg::REG_EARLY_EXIT:    prdata = bdss_pkg::APB_DATA_BITS'(r_early_en);
            bdss_pkg::REG_EXIT_LIMIT:    prdata = bdss_pkg::APB_DATA_BITS'(r_limit);
            bdss_pkg::REG_CUR_WIDTH:     prdata = bdss_pkg::APB_DATA_BITS'(r_cur_w);
            bdss_pkg::REG_CUR_HEIGHT:    prdata = bdss_pkg::APB_DATA_BITS'(r_cur_h);
            bdss_pkg::REG_REF_WIDTH:     prdata = bdss_pkg::APB_DATA_BITS'(r_ref_w);
            bdss_pkg::REG_REF_HEIGHT:    prdata = bdss_pkg::APB_DATA_BITS'(r_ref_h);
            default:                     prdata = '0;
        endcase
    end

    // saturating accumulate and mismatch code (limit + code stays below 2^32)
    assign mismatch = (r_cur_w != r_ref_w) || (r_cur_h != r_ref_h);
    assign sum_wide = ADD_BITS'(r_sum) + ADD_BITS'(t_term);
    assign sum_sat  = (sum_wide[ADD_BITS-1:SUM_BITS] != '0) ? '1 : sum_wide[SUM_BITS-1:0];
    assign code     = r_early_en ? (bdss_pkg::CODE_BITS'(r_limit) + bdss_pkg::MISMATCH_CODE)
                                 : bdss_pkg::MISMATCH_CODE;

    // per-pair decision
    always_comb begin
        n_sum   = r_sum;
        n_fin   = r_fin;
        emit    = 1'b0;
        n_dist  = bdss_pkg::DIST_BITS'(sum_sat);
        n_early = 1'b0;
        n_mism  = 1'b0;
        if (mismatch) begin
            n_dist = bdss_pkg::DIST_BITS'(code);
            n_mism = 1'b1;
            if (t_last) begin
                emit  = 1'b1;
                n_sum = '0;
                n_fin = 1'b0;
            end
        end else if (r_fin) begin
            if (t_last) begin
                n_sum = '0;
                n_fin = 1'b0;
            end
        end else if (r_early_en && (sum_sat > SUM_BITS'(r_limit))) begin
            emit = 1'b1;
            if (t_last) begin
                n_sum = '0;
                n_fin = 1'b0;
            end else begin
                n_sum   = sum_sat;
                n_fin   = 1'b1;
                n_early = 1'b1;
            end
        end else if (t_last) begin
            emit  = 1'b1;
            n_sum = '0;
            n_fin = 1'b0;
        end else begin
            n_sum = sum_sat;
        end
    end

    // a pair that emits waits for room in the result register
    assign out_free = !r_o_vld || i_ready;
    assign t_ready  = !emit || out_free;
    assign t_move   = t_valid && t_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_fin <= 1'b0;
        end else if (t_move) begin
            r_sum <= n_sum;
            r_fin <= n_fin;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (t_move && emit) begin
            r_o_vld <= 1'b1;
        end else if (i_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (t_move && emit) begin
            r_dist  <= n_dist;
            r_early <= n_early;
            r_mism  <= n_mism;
        end
    end

    assign o_valid         = r_o_vld;
    assign o_distortion    = r_dist;
    assign o_exited_early  = r_early;
    assign o_size_mismatch = r_mism;

endmodule

>>> tb/block_distortion_sad_sse_unit_tb.sv
// Self-checking testbench for the SAD/SSE block distortion unit.
// Predicts each result from the accepted sample pairs and APB writes.
// Depends on bdss_pkg and block_distortion_sad_sse_unit.
module block_distortion_sad_sse_unit_tb;

    localparam bit [bdss_pkg::DIST_BITS-1:0] DIST_MAX = {bdss_pkg::DIST_BITS{1'b1}};
    localparam int                           SETTLE_CYCLES = 8;

    typedef struct packed {
        bit                             metric;
        bit                             early;
        bit [bdss_pkg::LIMIT_BITS-1:0]  limit;
        bit [bdss_pkg::DIM_BITS-1:0]    cw;
        bit [bdss_pkg::DIM_BITS-1:0]    ch;
        bit [bdss_pkg::DIM_BITS-1:0]    rw;
        bit [bdss_pkg::DIM_BITS-1:0]    rh;
    } blk_cfg_t;

    typedef struct packed {
        bit [bdss_pkg::DIST_BITS-1:0] value;
        bit                           early;
        bit                           mism;
    } dist_res_t;

    // Typed expectation travelling with each request
    typedef struct packed {
        bit        on;
        dist_res_t res;
    } pin_t;

    typedef struct packed {
        bit [2:0]                      cfg;
        bit [15:0]                     cur_s;
        bit [15:0]                     ref_s;
        bit                            last;
        bit                            pinned;
        bit [bdss_pkg::DIST_BITS-1:0]  p_dist;
        bit                            p_early;
        bit                            p_mism;
    } stim_row_t;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  i_valid;
    logic                                  o_ready;
    logic [bdss_pkg::SAMPLE_PORT_BITS-1:0] i_cur_sample;
    logic [bdss_pkg::SAMPLE_PORT_BITS-1:0] i_ref_sample;
    logic                                  i_last_pair;
    logic                                  o_valid;
    logic                                  i_ready;
    logic [bdss_pkg::DIST_BITS-1:0]        o_distortion;
    logic                                  o_exited_early;
    logic                                  o_size_mismatch;
    logic                                  psel;
    logic                                  penable;
    logic                                  pwrite;
    logic [bdss_pkg::APB_ADDR_BITS-1:0]    paddr;
    logic [bdss_pkg::APB_DATA_BITS-1:0]    pwdata;
    logic [bdss_pkg::APB_DATA_BITS-1:0]    prdata;
    logic                                  pready;

    block_distortion_sad_sse_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cur_sample    (i_cur_sample),
        .i_ref_sample    (i_ref_sample),
        .i_last_pair     (i_last_pair),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_distortion    (o_distortion),
        .o_exited_early  (o_exited_early),
        .o_size_mismatch (o_size_mismatch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Register settings for the directed part; entry 0 is the reset state
    localparam blk_cfg_t CFG_TAB [7] = '{
        '{1'b0, 1'b0, 31'd0,          7'd16, 7'd16, 7'd16, 7'd16},
        '{1'b1, 1'b0, 31'd0,          7'd64, 7'd64, 7'd64, 7'd64},
        '{1'b0, 1'b1, 31'd100,        7'd1,  7'd1,  7'd1,  7'd1},
        '{1'b0, 1'b0, 31'd0,          7'd64, 7'd16, 7'd16, 7'd16},
        '{1'b1, 1'b1, 31'h7FFF_FFFF,  7'd16, 7'd1,  7'd16, 7'd64},
        '{1'b0, 1'b1, 31'd0,          7'd1,  7'd64, 7'd1,  7'd64},
        '{1'b1, 1'b1, 31'h7FFF_FFFF,  7'd64, 7'd1,  7'd64, 7'd1}
    };

    // Directed requests: cfg, cur, ref, last, pinned, distortion, early, mismatch
    localparam stim_row_t DIR_ROWS [22] = '{
        // reset settings: SAD extremes both ways, zero difference
        '{3'd0, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 48'd65535,      1'b0, 1'b0},
        '{3'd0, 16'h8000, 16'h7FFF, 1'b1, 1'b1, 48'd65535,      1'b0, 1'b0},
        '{3'd0, 16'h0000, 16'h0000, 1'b1, 1'b1, 48'd0,          1'b0, 1'b0},
        '{3'd0, 16'd100,  16'd50,   1'b0, 1'b0, 48'd0,          1'b0, 1'b0},
        '{3'd0, 16'hFFF9, 16'd3,    1'b1, 1'b0, 48'd0,          1'b0, 1'b0},
        // SSE at the largest block size
        '{3'd1, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 48'd4294836225, 1'b0, 1'b0},
        '{3'd1, 16'd5,    16'hFFFB, 1'b0, 1'b0, 48'd0,          1'b0, 1'b0},
        '{3'd1, 16'hFFFF, 16'd1,    1'b1, 1'b0, 48'd0,          1'b0, 1'b0},
        // early exit mid-block, ignored tail, limit met exactly, crossed on last
        '{3'd2, 16'd50,   16'd0,    1'b0, 1'b0, 48'd0,          1'b0, 1'b0},
        '{3'd2, 16'd60,   16'd0,    1'b0, 1'b0, 48'd0,          1'b0, 1'b0},
        '{3'd2, 16'd1000, 16'd0,    1'b0, 1'b0, 48'd0,          1'b0, 1'b0},
        '{3'd2, 16'd5,    16'd5,    1'b1, 1'b0, 48'd0,          1'b0, 1'b0},
        '{3'd2, 16'd100,  16'd0,    1'b1, 1'b0, 48'd0,          1'b0, 1'b0},
        '{3'd2, 16'd101,  16'd0,    1'b1, 1'b0, 48'd0,          1'b0, 1'b0},
        // width mismatch, plain code
        '{3'd3, 16'd1,    16'd2,    1'b0, 1'b0, 48'd0,          1'b0, 1'b0},
        '{3'd3, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 48'd10000000,   1'b0, 1'b1},
        // height mismatch with early exit: limit plus code
        '{3'd4, 16'h0000, 16'h0000, 1'b1, 1'b1, 48'd2157483647, 1'b0, 1'b1},
        // zero limit: equal is fine, one above exits
        '{3'd5, 16'h0000, 16'h0000, 1'b0, 1'b0, 48'd0,          1'b0, 1'b0},
        '{3'd5, 16'd1,    16'd0,    1'b0, 1'b1, 48'd1,          1'b1, 1'b0},
        '{3'd5, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 48'd0,          1'b0, 1'b0},
        // SSE over the largest limit mid-block, tail ignored
        '{3'd6, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 48'd0,          1'b0, 1'b0},
        '{3'd6, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 48'd0,          1'b0, 1'b0}
    };

    // Predictor state
    blk_cfg_t                      mdl_cfg;
    bit [bdss_pkg::DIST_BITS-1:0]  acc_sum;
    bit                            blk_done;

    dist_res_t dist_q[$];
    pin_t      pin_q[$];
    int        fail_cnt = 0;

    // Traffic shaping
    bit tx_steady;
    bit rx_steady;
    bit hold_req;
    bit hold_seen;
    int hold_cnt;

    function automatic bit [bdss_pkg::DIST_BITS-1:0] sat_sum(
        bit [bdss_pkg::DIST_BITS-1:0] a, bit [63:0] b);
        bit [64:0] s;
        s = {17'd0, a} + {1'b0, b};
        if (s > {17'd0, DIST_MAX})
            return DIST_MAX;
        return s[bdss_pkg::DIST_BITS-1:0];
    endfunction

    function automatic void predict_pair(input bit [15:0] c, input bit [15:0] r,
                                         input bit last, output bit has,
                                         output dist_res_t res);
        logic signed [16:0] diff;
        bit [16:0]          mag;
        bit [63:0]          term;
        bit                 mism;
        has = 1'b0;
        res = '0;
        mism = (mdl_cfg.cw != mdl_cfg.rw) || (mdl_cfg.ch != mdl_cfg.rh);
        if (mism) begin
            if (last) begin
                res.value = mdl_cfg.early ?
                    sat_sum({17'd0, mdl_cfg.limit}, 64'(bdss_pkg::MISMATCH_CODE)) :
                    bdss_pkg::DIST_BITS'(bdss_pkg::MISMATCH_CODE);
                res.mism = 1'b1;
                has = 1'b1;
                acc_sum = '0;
                blk_done = 1'b0;
            end
            return;
        end
        if (blk_done) begin
            if (last) begin
                acc_sum = '0;
                blk_done = 1'b0;
            end
            return;
        end
        diff = $signed({c[15], c}) - $signed({r[15], r});
        mag = (diff < 0) ? 17'(-diff) : 17'(diff);
        term = mdl_cfg.metric ? 64'(mag) * 64'(mag) : 64'(mag);
        acc_sum = sat_sum(acc_sum, term);
        if (mdl_cfg.early && acc_sum > {17'd0, mdl_cfg.limit}) begin
            res.value = acc_sum;
            has = 1'b1;
            if (last) begin
                acc_sum = '0;
                blk_done = 1'b0;
            end else begin
                res.early = 1'b1;
                blk_done = 1'b1;
            end
            return;
        end
        if (last) begin
            res.value = acc_sum;
            has = 1'b1;
            acc_sum = '0;
            blk_done = 1'b0;
        end
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random back-pressure, long hold-off on request
    initial begin
        hold_cnt  = 0;
        hold_seen = 1'b0;
        i_ready   <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                hold_cnt  = 300;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_ready <= 1'b0;
            end else if (rx_steady) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 18);
            end
        end
    end

    // Monitor: register writes, accepted requests and results
    always @(posedge i_clk) begin
        bit        has;
        dist_res_t res;
        pin_t      pin;
        dist_res_t exp_r;
        if (!i_rst_n) begin
            mdl_cfg = CFG_TAB[0];
            acc_sum = '0;
            blk_done = 1'b0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    bdss_pkg::REG_METRIC_SELECT: mdl_cfg.metric = pwdata[0];
                    bdss_pkg::REG_EARLY_EXIT:    mdl_cfg.early  = pwdata[0];
                    bdss_pkg::REG_EXIT_LIMIT:
                        mdl_cfg.limit = pwdata[bdss_pkg::LIMIT_BITS-1:0];
                    bdss_pkg::REG_CUR_WIDTH:     mdl_cfg.cw = pwdata[bdss_pkg::DIM_BITS-1:0];
                    bdss_pkg::REG_CUR_HEIGHT:    mdl_cfg.ch = pwdata[bdss_pkg::DIM_BITS-1:0];
                    bdss_pkg::REG_REF_WIDTH:     mdl_cfg.rw = pwdata[bdss_pkg::DIM_BITS-1:0];
                    bdss_pkg::REG_REF_HEIGHT:    mdl_cfg.rh = pwdata[bdss_pkg::DIM_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                predict_pair(i_cur_sample, i_ref_sample, i_last_pair, has, res);
                pin = pin_q.pop_front();
                if (pin.on) begin
                    has = 1'b1;
                    res = pin.res;
                end
                if (has)
                    dist_q.push_back(res);
            end
            if (o_valid && i_ready) begin
                if (dist_q.size() == 0) begin
                    $error("result with nothing expected: distortion %0d", o_distortion);
                    fail_cnt++;
                end else begin
                    exp_r = dist_q.pop_front();
                    if (o_distortion !== exp_r.value) begin
                        $error("distortion: expected %0d, got %0d", exp_r.value, o_distortion);
                        fail_cnt++;
                    end
                    if (o_exited_early !== exp_r.early) begin
                        $error("exited_early: expected %0b, got %0b",
                               exp_r.early, o_exited_early);
                        fail_cnt++;
                    end
                    if (o_size_mismatch !== exp_r.mism) begin
                        $error("size_mismatch: expected %0b, got %0b",
                               exp_r.mism, o_size_mismatch);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // Offer one pair and wait until it is taken; valid drops only for random gaps
    task automatic push_pair(bit [15:0] c, bit [15:0] r, bit last, pin_t pin);
        pin_q.push_back(pin);
        if (!tx_steady && $urandom_range(0, 99) < 18) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cur_sample <= c;
        i_ref_sample <= r;
        i_last_pair  <= last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stop sending, drain every expected result, let trailing pairs clear
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (dist_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [bdss_pkg::REG_IDX_BITS-1:0] idx,
                             logic [bdss_pkg::APB_DATA_BITS-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_cfg(blk_cfg_t c);
        write_reg(bdss_pkg::REG_METRIC_SELECT, 32'(c.metric));
        write_reg(bdss_pkg::REG_EARLY_EXIT,    32'(c.early));
        write_reg(bdss_pkg::REG_EXIT_LIMIT,    32'(c.limit));
        write_reg(bdss_pkg::REG_CUR_WIDTH,     32'(c.cw));
        write_reg(bdss_pkg::REG_CUR_HEIGHT,    32'(c.ch));
        write_reg(bdss_pkg::REG_REF_WIDTH,     32'(c.rw));
        write_reg(bdss_pkg::REG_REF_HEIGHT,    32'(c.rh));
    endtask

    function automatic bit [bdss_pkg::DIM_BITS-1:0] pick_dim();
        case ($urandom_range(0, 3))
            0:       return 7'd1;
            1:       return 7'd64;
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic blk_cfg_t pick_cfg();
        blk_cfg_t c;
        c.metric = 1'($urandom_range(0, 1));
        c.early  = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 4))
            0:       c.limit = '0;
            1:       c.limit = 31'h7FFF_FFFF;
            2:       c.limit = 31'($urandom_range(0, 200000));
            default: c.limit = 31'($urandom());
        endcase
        c.cw = pick_dim();
        c.ch = pick_dim();
        c.rw = c.cw;
        c.rh = c.ch;
        // occasional size mismatch
        if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1) != 0)
                c.rw = pick_dim();
            else
                c.rh = pick_dim();
        end
        return c;
    endfunction

    function automatic bit [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 31)) - 16'd16;
            default: return 16'($urandom());
        endcase
    endfunction

    // Stimulus
    initial begin
        int   cfg_sel;
        int   rnd_items;
        int   phase_items;
        int   phase;
        int   len;
        bit   broken;
        int   wait_cnt;
        pin_t no_pin;
        pin_t pin;

        no_pin       = '0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_req     = 1'b0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_cur_sample <= '0;
        i_ref_sample <= '0;
        i_last_pair  <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; the first rows run on the reset settings
        cfg_sel = 0;
        foreach (DIR_ROWS[n]) begin
            if (int'(DIR_ROWS[n].cfg) != cfg_sel) begin
                settle();
                cfg_sel = int'(DIR_ROWS[n].cfg);
                write_cfg(CFG_TAB[cfg_sel]);
            end
            pin.on  = DIR_ROWS[n].pinned;
            pin.res = '{DIR_ROWS[n].p_dist, DIR_ROWS[n].p_early, DIR_ROWS[n].p_mism};
            push_pair(DIR_ROWS[n].cur_s, DIR_ROWS[n].ref_s, DIR_ROWS[n].last, pin);
        end
        settle();

        // Random blocks over several settings; one phase runs without gaps
        rnd_items = 0;
        phase = 0;
        while (rnd_items < 440) begin
            settle();
            write_cfg(pick_cfg());
            tx_steady = (phase == 3);
            rx_steady = (phase == 3);
            phase_items = 0;
            while (phase_items < 60) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80)
                                                  : $urandom_range(1, 12);
                broken = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < len; k++) begin
                    push_pair(pick_sample(), pick_sample(),
                              broken ? ($urandom_range(0, 3) == 0) : (k == len - 1),
                              no_pin);
                    phase_items++;
                end
            end
            rnd_items += phase_items;
            phase++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        settle();

        // Back-pressure: results held off while one-pair blocks keep coming
        write_cfg('{1'b0, 1'b0, 31'd0, 7'd1, 7'd1, 7'd1, 7'd1});
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++)
            push_pair(pick_sample(), pick_sample(), 1'b1, no_pin);

        // Drain with a bound, then look for strays
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait_cnt = 0;
        while (dist_q.size() != 0 && wait_cnt < 5000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (dist_q.size() != 0)
            $error("%0d expected results never arrived", dist_q.size());
        if (fail_cnt == 0 && dist_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
